### rtl/core/sre_pkg.sv
// Shared types, constants and helpers for the signed radix digit emitter.
package sre_pkg;

  // Fixed field widths.
  localparam int NUM_W      = 32;
  localparam int SYM_W      = 8;
  localparam int NUM_SYMS   = 16;
  localparam int SYM_IDX_W  = 4;
  localparam int ALPHA_W    = NUM_SYMS * SYM_W;
  localparam int BASE_W     = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_BITS_PER_CYC = 8;
  localparam int DIV_CYCLES       = NUM_W / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);

  // Character codes.
  localparam logic [SYM_W-1:0] CHAR_PLUS        = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS       = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_FIRST_PRINT = 8'd33;
  localparam logic [SYM_W-1:0] CHAR_LAST_PRINT  = 8'd126;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BASE_LENGTH   = 2'd0,
    REG_ALPHABET_LOW  = 2'd1,
    REG_ALPHABET_HIGH = 2'd2
  } cfg_reg_t;

  // Status reported by the divider to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Pick one symbol byte out of the packed alphabet.
  function automatic logic [SYM_W-1:0] symbol_at(input logic [ALPHA_W-1:0] alphabet,
                                                 input logic [SYM_IDX_W-1:0] idx);
    return alphabet[{idx, 3'b000} +: SYM_W];
  endfunction

endpackage

### rtl/core/sre_divider.sv
// Iterative restoring divider of a 32-bit word by a small radix.
module sre_divider #(
  parameter int DIG_W = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [sre_pkg::NUM_W-1:0] dividend,
  input  logic [DIG_W:0]            divisor,
  output logic [sre_pkg::NUM_W-1:0] quotient,
  output logic [DIG_W-1:0]          remainder,
  output sre_pkg::div_status_t      status
);
  import sre_pkg::*;

  localparam int REM_W = DIG_W + 1;

  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [DIG_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // Eight restoring steps per cycle on a narrow partial remainder.
  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [NUM_W-1:0] q;
    r = {1'b0, rem_r};
    q = quo_r;
    for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
      r = {r[DIG_W-1:0], q[NUM_W-1]};
      q = {q[NUM_W-2:0], 1'b0};
      if (r >= divisor) begin
        r    = r - divisor;
        q[0] = 1'b1;
      end
    end
    quo_nxt = q;
    rem_nxt = r[DIG_W-1:0];
  end

  // Control: step counter, busy and a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient    = quo_r;
  assign remainder   = rem_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

### rtl/core/signed_radix_digit_emitter.sv
// Signed radix digit emitter: renders a signed 32-bit number as text in a configured radix.
// Operation: the alphabet check tests the symbols in use (2 to 16) one after another, then each
// digit comes from the shared divider (4 steps of 8 bits plus a hand-off), then one word
// leaves per cycle while the output side is ready.
// One number is processed at a time; in_tready is high only between numbers.
// Reset (rst_n low, synchronous) clears the configuration registers, the sequencer and the output valid.
module signed_radix_digit_emitter #(
  parameter int MAX_BASE = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sre_pkg::NUM_W-1:0]      in_tdata,   // [31:0] number
  // Output stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sre_pkg::SYM_W-1:0]      out_tdata,  // [7:0] symbol
  output logic                           out_tlast,
  // Configuration writes.
  input  logic                           cfg_we,
  input  logic [sre_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sre_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sre_pkg::*;

  localparam int DIG_W       = $clog2(MAX_BASE);
  localparam int REM_W       = DIG_W + 1;
  localparam int ND_W        = $clog2(NUM_W + 1);
  localparam int STACK_IDX_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  // Configuration registers.
  logic [BASE_W-1:0]  base_len_r;
  logic [ALPHA_W-1:0] alpha_r;

  // Sequencer state.
  state_t               state_r, state_nxt;
  logic [SYM_IDX_W-1:0] idx_r, idx_nxt;
  logic [ND_W-1:0]      nd_r, nd_nxt;
  logic                 neg_r, neg_nxt;
  logic                 sign_pend_r, sign_nxt;
  logic [NUM_W-1:0]     mag_r, mag_nxt;

  // Digit stack, filled least significant first and read back in reverse.
  logic [DIG_W-1:0]     stack_r [NUM_W];
  logic [DIG_W-1:0]     top_dig_r;
  logic                 push;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]     out_sym_r, out_sym_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_load;

  // Divider interface.
  logic                 div_start;
  logic [NUM_W-1:0]     div_dividend;
  logic [NUM_W-1:0]     div_quo;
  logic [DIG_W-1:0]     div_rem;
  div_status_t          div_stat;

  // Check and pop helpers.
  logic                 len_ok;
  logic [SYM_W-1:0]     cur_sym;
  logic                 sym_bad;
  logic                 sym_dup;
  logic                 check_last;
  logic [STACK_IDX_W-1:0] top_idx;
  logic [SYM_W-1:0]     pop_sym;
  logic [NUM_W-1:0]     in_mag;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_len_r <= '0;
      alpha_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BASE_LENGTH:   base_len_r <= cfg_wdata[BASE_W-1:0];
        REG_ALPHABET_LOW:  alpha_r[CFG_DATA_W-1:0] <= cfg_wdata;
        REG_ALPHABET_HIGH: alpha_r[ALPHA_W-1:CFG_DATA_W] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Radix bounds, and the checks on the symbol under test against all later symbols.
  assign len_ok     = (base_len_r >= BASE_W'(2)) && (base_len_r <= BASE_W'(MAX_BASE));
  assign cur_sym    = symbol_at(alpha_r, idx_r);
  assign sym_bad    = (cur_sym < CHAR_FIRST_PRINT) || (cur_sym > CHAR_LAST_PRINT) ||
                      (cur_sym == CHAR_PLUS) || (cur_sym == CHAR_MINUS);
  assign check_last = ({1'b0, idx_r} == base_len_r - BASE_W'(1));

  always_comb begin
    sym_dup = 1'b0;
    for (int j = 0; j < NUM_SYMS; j++) begin
      if ((BASE_W'(j) > {1'b0, idx_r}) && (BASE_W'(j) < base_len_r) &&
          (symbol_at(alpha_r, SYM_IDX_W'(j)) == cur_sym)) begin
        sym_dup = 1'b1;
      end
    end
  end

  // Magnitude of the incoming number as an unsigned word.
  assign in_mag  = in_tdata[NUM_W-1] ? (NUM_W'(0) - in_tdata) : in_tdata;

  // Address of the digit that will be on top after this cycle.
  assign top_idx = STACK_IDX_W'(nd_nxt - ND_W'(1));

  // Top of the digit stack mapped through the alphabet.
  assign pop_sym = symbol_at(alpha_r, SYM_IDX_W'(top_dig_r));

  assign out_load     = !out_valid_r || out_tready;
  assign div_dividend = (state_r == ST_CHECK) ? mag_r : div_quo;

  // Sequencer: check alphabet (a number under a bad one is dropped), divide repeatedly, then emit sign and digits.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    nd_nxt        = nd_r;
    neg_nxt       = neg_r;
    sign_nxt      = sign_pend_r;
    mag_nxt       = mag_r;
    div_start     = 1'b0;
    push          = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt   = in_tdata[NUM_W-1];
          mag_nxt   = in_mag;
          idx_nxt   = '0;
          nd_nxt    = '0;
          state_nxt = len_ok ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (sym_bad || sym_dup) begin
          state_nxt = ST_IDLE;
        end else if (check_last) begin
          div_start = 1'b1;
          state_nxt = ST_DIVIDE;
        end else begin
          idx_nxt = idx_r + SYM_IDX_W'(1);
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          push   = 1'b1;
          nd_nxt = nd_r + ND_W'(1);
          if ((div_quo == '0) || (nd_r == ND_W'(NUM_W - 1))) begin
            sign_nxt  = neg_r;
            state_nxt = ST_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_sym_nxt  = CHAR_MINUS;
            out_last_nxt = 1'b0;
            sign_nxt     = 1'b0;
          end else begin
            out_sym_nxt  = pop_sym;
            out_last_nxt = (nd_r == ND_W'(1));
            nd_nxt       = nd_r - ND_W'(1);
            if (nd_r == ND_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nd_r        <= '0;
      sign_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nd_r        <= nd_nxt;
      sign_pend_r <= sign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers. The top digit is read ahead; a push forwards the new digit.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    if (push) begin
      stack_r[nd_r[STACK_IDX_W-1:0]] <= div_rem;
      top_dig_r <= div_rem;
    end else begin
      top_dig_r <= stack_r[top_idx];
    end
  end

  // Shared divider.
  sre_divider #(
    .DIG_W (DIG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (REM_W'(base_len_r)),
    .quotient  (div_quo),
    .remainder (div_rem),
    .status    (div_stat)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

  // The divider is never restarted while a division is running.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The digit count never exceeds one digit per input bit.
  a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r <= ND_W'(NUM_W))
    else $error("digit count out of range");

  // Popping a digit needs a non-empty stack.
  a_emit_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !sign_pend_r) |-> (nd_r != '0))
    else $error("emit with empty digit stack");

  // An accepted number goes to the alphabet check or is dropped.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_CHECK || state_r == ST_IDLE))
    else $error("unexpected state after accept");

endmodule

### test/tb_top.sv
// Self-checking testbench for the signed radix digit emitter: directed table, then random.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sre_pkg::*;

  localparam int MAX_RADIX     = 16;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 9;

  // One character of rendered text as it leaves the block.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } text_char_t;

  // Register contents for one alphabet setting.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] base_word;
    logic [CFG_DATA_W-1:0] low_word;
    logic [CFG_DATA_W-1:0] high_word;
  } alpha_cfg_t;

  // Fixed alphabet settings used by the directed table.
  typedef enum int {
    ALPHA_RESET,
    ALPHA_DEC,
    ALPHA_BIN,
    ALPHA_HEX,
    ALPHA_EDGE,
    ALPHA_PLUS,
    ALPHA_DUP,
    ALPHA_WIDE17,
    ALPHA_ONE,
    ALPHA_SPACE,
    ALPHA_DEL,
    ALPHA_WIDE31,
    ALPHA_MINUS
  } alpha_preset_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [NUM_W-1:0]      in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SYM_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_BASE_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the configuration registers.
  logic [BASE_W-1:0]     radix_reg = '0;
  logic [CFG_DATA_W-1:0] alpha_lo_reg = '0;
  logic [CFG_DATA_W-1:0] alpha_hi_reg = '0;

  text_char_t    expected_chars[$];
  alpha_preset_t row_preset[$];
  logic [31:0]   row_number[$];
  bit            row_has_golden[$];
  string         row_golden[$];

  int mismatch_count   = 0;
  int numbers_sent     = 0;
  int chars_checked    = 0;
  int alphabets_loaded = 0;
  int stall_cycles     = 0;
  bit hold_request     = 1'b0;
  bit hold_done        = 1'b0;
  bit quiet            = 1'b0;

  signed_radix_digit_emitter #(.MAX_BASE(MAX_RADIX)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] number
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] symbol
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Symbol byte at a digit position of the configured alphabet.
  function automatic logic [SYM_W-1:0] alphabet_char(input int pos);
    logic [2*CFG_DATA_W-1:0] packed_alpha;
    packed_alpha = {alpha_hi_reg, alpha_lo_reg};
    return packed_alpha[pos*8 +: 8];
  endfunction

  // The alphabet must be 2..MAX_RADIX printable, distinct, sign-free symbols.
  function automatic bit alphabet_usable();
    int               n;
    logic [SYM_W-1:0] c;
    n = int'(radix_reg);
    if (n < 2 || n > MAX_RADIX) return 1'b0;
    for (int i = 0; i < n; i++) begin
      c = alphabet_char(i);
      if (c < CHAR_FIRST_PRINT || c > CHAR_LAST_PRINT || c == CHAR_PLUS || c == CHAR_MINUS)
        return 1'b0;
      for (int j = i + 1; j < n; j++)
        if (alphabet_char(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the characters that render one accepted number.
  function automatic void predict_text(input logic [31:0] raw);
    logic [31:0]      mag;
    logic [SYM_W-1:0] digit_chars[$];
    text_char_t       ch;
    if (!alphabet_usable()) return;
    // Magnitude as unsigned, so the most negative value needs no special path.
    mag = raw[31] ? (32'd0 - raw) : raw;
    do begin
      digit_chars.push_front(alphabet_char(int'(mag % radix_reg)));
      mag = mag / radix_reg;
    end while (mag != 0);
    if (raw[31]) begin
      ch.symbol = CHAR_MINUS;
      ch.last   = 1'b0;
      expected_chars.push_back(ch);
    end
    foreach (digit_chars[i]) begin
      ch.symbol = digit_chars[i];
      ch.last   = (i == digit_chars.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void push_golden(input string text);
    text_char_t ch;
    for (int i = 0; i < text.len(); i++) begin
      ch.symbol = text[i];
      ch.last   = (i == text.len() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic alpha_cfg_t alphabet_preset(input alpha_preset_t id);
    alpha_cfg_t cfg;
    cfg = '0;
    case (id)
      ALPHA_DEC:    cfg = '{64'd10, 64'h3736353433323130, 64'h3938};
      ALPHA_BIN:    cfg = '{64'd2, 64'h3130, 64'h0};
      ALPHA_HEX:    cfg = '{64'd16, 64'h3736353433323130, 64'h4645444342413938};
      // Radix 3 of '!', '~', 'x'; junk in unused bytes and in the upper base bits.
      ALPHA_EDGE:   cfg = '{64'hFFFF_FFFF_FFFF_FFE3, 64'hFF20_2100_2B78_7E21, '1};
      ALPHA_PLUS:   cfg = '{64'd10, 64'h37362B3433323130, 64'h3938};
      ALPHA_DUP:    cfg = '{64'd10, 64'h3736353433323130, 64'h3038};
      ALPHA_WIDE17: cfg = '{64'd17, 64'h3736353433323130, 64'h4645444342413938};
      ALPHA_ONE:    cfg = '{64'd1, 64'h30, 64'h0};
      ALPHA_SPACE:  cfg = '{64'd3, 64'h203130, 64'h0};
      ALPHA_DEL:    cfg = '{64'd3, 64'h7F3130, 64'h0};
      ALPHA_WIDE31: cfg = '{64'd31, 64'h3736353433323130, 64'h4645444342413938};
      ALPHA_MINUS:  cfg = '{64'd3, 64'h2D3130, 64'h0};
      default:      cfg = '0;
    endcase
    return cfg;
  endfunction

  // Distinct legal symbols for the radix; spoiled settings may break one rule.
  function automatic alpha_cfg_t random_alphabet(input int radix, input bit spoil);
    alpha_cfg_t              cfg;
    logic [2*CFG_DATA_W-1:0] packed_alpha;
    logic [SYM_W-1:0]        c;
    bit                      clash;
    int                      a;
    int                      b;
    packed_alpha  = {$urandom, $urandom, $urandom, $urandom};
    cfg.base_word = ({$urandom, $urandom} & ~64'h1F) | CFG_DATA_W'(radix);
    for (int i = 0; i < radix; i++) begin
      do begin
        c     = SYM_W'($urandom_range(CHAR_FIRST_PRINT, CHAR_LAST_PRINT));
        clash = (c == CHAR_PLUS || c == CHAR_MINUS);
        for (int j = 0; j < i; j++)
          if (packed_alpha[j*8 +: 8] == c) clash = 1'b1;
      end while (clash);
      packed_alpha[i*8 +: 8] = c;
    end
    if (spoil) begin
      a = $urandom_range(0, radix - 1);
      b = (a + $urandom_range(1, radix - 1)) % radix;
      case ($urandom_range(0, 2))
        0:       packed_alpha[a*8 +: 8] = SYM_W'($urandom_range(0, 255));
        1:       packed_alpha[a*8 +: 8] = packed_alpha[b*8 +: 8];
        default: cfg.base_word = CFG_DATA_W'($urandom_range(0, 31));
      endcase
    end
    cfg.low_word  = packed_alpha[CFG_DATA_W-1:0];
    cfg.high_word = packed_alpha[2*CFG_DATA_W-1:CFG_DATA_W];
    return cfg;
  endfunction

  function automatic logic [31:0] random_number();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: v = 32'd0 - $urandom_range(1, 40);
      3: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h7FFF_FFFF;
          4:       v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      4:       v = $urandom >> $urandom_range(0, 31);
      default: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
    endcase
    return v;
  endfunction

  function automatic int sender_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 5);
    return 0;
  endfunction

  task automatic add_row(input alpha_preset_t preset, input logic [31:0] number,
                         input bit has_golden, input string golden);
    row_preset.push_back(preset);
    row_number.push_back(number);
    row_has_golden.push_back(has_golden);
    row_golden.push_back(golden);
  endtask

  // Offer one number, called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_number(input logic [31:0] value, input int gap,
                             input bit has_golden, input string golden);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    if (has_golden) push_golden(golden);
    else predict_text(value);
    numbers_sent++;
    @(negedge clk);
  endtask

  // Drop the input, wait for every expected word, then let a rejected number finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers on consecutive cycles; only while the block is idle.
  task automatic load_alphabet(input alpha_cfg_t cfg);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_BASE_LENGTH;
    cfg_wdata <= cfg.base_word;
    @(negedge clk);
    cfg_addr  <= REG_ALPHABET_LOW;
    cfg_wdata <= cfg.low_word;
    @(negedge clk);
    cfg_addr  <= REG_ALPHABET_HIGH;
    cfg_wdata <= cfg.high_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    radix_reg    = cfg.base_word[BASE_W-1:0];
    alpha_lo_reg = cfg.low_word;
    alpha_hi_reg = cfg.high_word;
    alphabets_loaded++;
  endtask

  // Output side readiness: random stall bursts, one long hold-off, none at the end.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each outgoing word with the oldest expected character.
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected word: expected none, got symbol %h last %b",
                 $time, out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_tdata !== want.symbol) begin
          $display("%0t: symbol mismatch: expected %h, got %h", $time, want.symbol, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    alpha_preset_t current_preset;
    bit            spoil;
    int            radix;
    int            item_count;

    // Directed table: reset state, extremes, every rejection rule.
    add_row(ALPHA_RESET,  32'd123,          1'b1, "");
    add_row(ALPHA_RESET,  32'hFFFF_FFFB,    1'b1, "");
    add_row(ALPHA_DEC,    32'd0,            1'b1, "0");
    add_row(ALPHA_DEC,    32'd7,            1'b1, "7");
    add_row(ALPHA_DEC,    32'hFFFF_FFFF,    1'b1, "-1");
    add_row(ALPHA_DEC,    32'h7FFF_FFFF,    1'b1, "2147483647");
    add_row(ALPHA_DEC,    32'h8000_0000,    1'b1, "-2147483648");
    add_row(ALPHA_DEC,    32'd1000,         1'b0, "");
    add_row(ALPHA_BIN,    32'd0,            1'b1, "0");
    add_row(ALPHA_BIN,    32'h7FFF_FFFF,    1'b0, "");
    add_row(ALPHA_BIN,    32'h8000_0000,    1'b0, "");
    add_row(ALPHA_BIN,    32'd5,            1'b1, "101");
    add_row(ALPHA_HEX,    32'hFFFF_FFFF,    1'b1, "-1");
    add_row(ALPHA_HEX,    32'h7FFF_FFFF,    1'b1, "7FFFFFFF");
    add_row(ALPHA_HEX,    32'h8000_0000,    1'b1, "-80000000");
    add_row(ALPHA_HEX,    32'h0123_ABCD,    1'b1, "123ABCD");
    add_row(ALPHA_EDGE,   32'd8,            1'b0, "");
    add_row(ALPHA_PLUS,   32'd42,           1'b1, "");
    add_row(ALPHA_DUP,    32'd42,           1'b1, "");
    add_row(ALPHA_WIDE17, 32'd42,           1'b1, "");
    add_row(ALPHA_ONE,    32'd0,            1'b1, "");
    add_row(ALPHA_SPACE,  32'd9,            1'b1, "");
    add_row(ALPHA_DEL,    32'd9,            1'b1, "");
    add_row(ALPHA_WIDE31, 32'd9,            1'b1, "");
    add_row(ALPHA_MINUS,  32'd9,            1'b1, "");

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    current_preset = ALPHA_RESET;
    foreach (row_number[i]) begin
      if (row_preset[i] != current_preset) begin
        settle();
        load_alphabet(alphabet_preset(row_preset[i]));
        current_preset = row_preset[i];
      end
      send_number(row_number[i], sender_gap(), row_has_golden[i], row_golden[i]);
    end

    // Random phases: mostly legal alphabets, a few spoiled ones between them.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      spoil = (phase % 4 == 2);
      if (phase == 0) radix = 2;
      else if (phase == 1) radix = MAX_RADIX;
      else radix = $urandom_range(2, MAX_RADIX);
      settle();
      load_alphabet(random_alphabet(radix, spoil));
      if (phase == 1) hold_request = 1'b1;
      if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
      item_count = spoil ? 6 : 28;
      for (int k = 0; k < item_count; k++)
        send_number(random_number(), sender_gap(), 1'b0, "");
    end

    settle();
    $display("Converted %0d numbers under %0d alphabet settings, %0d characters checked.",
             numbers_sent, alphabets_loaded, chars_checked);
    $display("Radix 2 to 16 and rejected alphabets, with stalls and one long output hold-off.");
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
